// ----- src/cidc_pkg.sv -----
// cidc_pkg: shared types, codes and constants of the chunked image download controller
// used by every module under src

package cidc_pkg;

   localparam int CHUNK_W        = 22;
   localparam int PAGE_BYTES_DEF = 2048;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [CHUNK_W-1:0] CHUNK_MAX = {CHUNK_W{1'b1}};

   // request actions
   localparam logic [2:0] ACT_START = 3'd0;
   localparam logic [2:0] ACT_TICK  = 3'd1;
   localparam logic [2:0] ACT_META  = 3'd2;
   localparam logic [2:0] ACT_CHUNK = 3'd3;
   localparam logic [2:0] ACT_PEER  = 3'd4;

   // result kinds
   localparam logic [2:0] KIND_REQ_META   = 3'd0;
   localparam logic [2:0] KIND_REQ_CHUNK  = 3'd1;
   localparam logic [2:0] KIND_PAGE_WRITE = 3'd2;
   localparam logic [2:0] KIND_DONE       = 3'd3;
   localparam logic [2:0] KIND_REJECT     = 3'd4;

   // completion codes
   localparam logic [1:0] RC_SUCCESS = 2'd0;
   localparam logic [1:0] RC_TIMEOUT = 2'd1;
   localparam logic [1:0] RC_MAGIC   = 2'd2;
   localparam logic [1:0] RC_INVALID = 2'd3;

   // csr indexes
   localparam logic [1:0] CSR_FLASH_BASE = 2'd0;
   localparam logic [1:0] CSR_MAGIC      = 2'd1;
   localparam logic [1:0] CSR_MAX_ATT    = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT    = 2'd3;

   localparam logic [3:0]  MAX_ATT_RST = 4'd5;
   localparam logic [15:0] TIMEOUT_RST = 16'd1000;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_META,
      PH_CHUNK
   } phase_type;

   typedef struct packed {
      logic [2:0]         action;
      logic [31:0]        image_magic;
      logic [31:0]        image_size;
      logic [CHUNK_W-1:0] chunk_number;
   } req_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [CHUNK_W-1:0] chunk_index;
      logic [31:0]        write_address;
      logic [1:0]         result_code;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] flash_base;
      logic [31:0] expected_magic;
      logic [3:0]  max_attempts;
      logic [15:0] step_timeout;
   } cfg_type;

   // one result as the front leaves it; the back adds flash_base to offset
   typedef struct packed {
      logic [2:0]         kind;
      logic [CHUNK_W-1:0] chunk;
      logic [31:0]        offset;
      logic [1:0]         code;
   } item_type;

   typedef struct packed {
      logic     two;
      item_type r0;
      item_type r1;
   } entry_type;

endpackage

// ----- src/cidc_front.sv -----
// cidc_front: download state, classifies each request and builds its results
// depends on cidc_pkg

module cidc_front import cidc_pkg::*; #(
   parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      req_accept,
   input  req_type   req,
   output logic      q_push,
   output entry_type q_entry
);

   localparam int PAGE_W = $clog2(PAGE_BYTES + 1);
   localparam int LIM_W  = 32 + PAGE_W;
   // size at or above this gives more chunks than the index can hold
   localparam logic [LIM_W-1:0] SIZE_LIMIT = LIM_W'(CHUNK_MAX) * LIM_W'(PAGE_BYTES);
   localparam logic [32:0] PAGE_STEP = 33'(PAGE_BYTES);

   phase_type          phase_ff, phase_in;
   logic [3:0]         attempt_ff, attempt_in;
   logic [15:0]        wait_ff, wait_in;
   logic [CHUNK_W-1:0] cur_ff, cur_in;
   logic [31:0]        offset_ff, offset_in;
   logic [31:0]        size_ff, size_in;

   logic [15:0]        wait_inc;
   logic [15:0]        limit;
   logic               tick_fire;
   logic               exhausted;
   logic               no_attempts;
   logic               magic_bad;
   logic               size_bad;
   logic               chunk_bad;
   logic [32:0]        next_off;
   logic               more;
   logic [CHUNK_W-1:0] cur_next;

   always_comb begin
      wait_inc    = (wait_ff != 16'hFFFF) ? wait_ff + 16'd1 : wait_ff;
      limit       = (cfg.step_timeout == 16'd0) ? 16'd1 : cfg.step_timeout;
      tick_fire   = wait_inc >= limit;
      exhausted   = attempt_ff >= cfg.max_attempts;
      no_attempts = cfg.max_attempts == 4'd0;
      magic_bad   = req.image_magic != cfg.expected_magic;
      size_bad    = (req.image_size == 32'd0) || (LIM_W'(req.image_size) >= SIZE_LIMIT);
      chunk_bad   = req.chunk_number != cur_ff;
      // more chunks remain while (cur + 1) * page <= size
      next_off    = {1'b0, offset_ff} + PAGE_STEP;
      more        = next_off <= {1'b0, size_ff};
      cur_next    = cur_ff + CHUNK_W'(1);
   end

   // next state
   always_comb begin
      phase_in   = phase_ff;
      attempt_in = attempt_ff;
      wait_in    = wait_ff;
      cur_in     = cur_ff;
      offset_in  = offset_ff;
      size_in    = size_ff;
      if (req_accept) begin
         case (req.action)
            ACT_START: begin
               if (phase_ff == PH_IDLE) begin
                  cur_in     = '0;
                  offset_in  = '0;
                  wait_in    = '0;
                  phase_in   = no_attempts ? PH_IDLE : PH_META;
                  attempt_in = no_attempts ? 4'd0 : 4'd1;
               end
            end
            ACT_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  wait_in = wait_inc;
                  if (tick_fire) begin
                     wait_in = '0;
                     if (exhausted) begin
                        phase_in   = PH_IDLE;
                        attempt_in = '0;
                     end else begin
                        attempt_in = attempt_ff + 4'd1;
                     end
                  end
               end
            end
            ACT_META: begin
               if (phase_ff == PH_META) begin
                  wait_in = '0;
                  size_in = req.image_size;
                  if (magic_bad || size_bad || no_attempts) begin
                     phase_in   = PH_IDLE;
                     attempt_in = '0;
                  end else begin
                     phase_in   = PH_CHUNK;
                     attempt_in = 4'd1;
                  end
               end
            end
            ACT_CHUNK: begin
               if (phase_ff == PH_CHUNK) begin
                  wait_in = '0;
                  if (chunk_bad) begin
                     phase_in   = PH_IDLE;
                     attempt_in = '0;
                  end else begin
                     cur_in    = cur_next;
                     offset_in = next_off[31:0];
                     if (!more || no_attempts) begin
                        phase_in   = PH_IDLE;
                        attempt_in = '0;
                     end else begin
                        attempt_in = 4'd1;
                     end
                  end
               end
            end
            ACT_PEER: begin
               phase_in   = PH_IDLE;
               attempt_in = '0;
               wait_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // results of the request
   always_comb begin
      q_push  = 1'b0;
      q_entry = '0;
      if (req_accept) begin
         case (req.action)
            ACT_START: begin
               q_push = 1'b1;
               if (phase_ff != PH_IDLE) begin
                  q_entry.r0.kind = KIND_REJECT;
               end else if (no_attempts) begin
                  q_entry.r0.kind = KIND_DONE;
                  q_entry.r0.code = RC_TIMEOUT;
               end else begin
                  q_entry.r0.kind = KIND_REQ_META;
               end
            end
            ACT_TICK: begin
               if (phase_ff != PH_IDLE && tick_fire) begin
                  q_push = 1'b1;
                  if (exhausted) begin
                     q_entry.r0.kind = KIND_DONE;
                     q_entry.r0.code = RC_TIMEOUT;
                  end else if (phase_ff == PH_META) begin
                     q_entry.r0.kind = KIND_REQ_META;
                  end else begin
                     q_entry.r0.kind  = KIND_REQ_CHUNK;
                     q_entry.r0.chunk = cur_ff;
                  end
               end
            end
            ACT_META: begin
               if (phase_ff == PH_META) begin
                  q_push = 1'b1;
                  if (magic_bad) begin
                     q_entry.r0.kind = KIND_DONE;
                     q_entry.r0.code = RC_MAGIC;
                  end else if (size_bad) begin
                     q_entry.r0.kind = KIND_DONE;
                     q_entry.r0.code = RC_INVALID;
                  end else if (no_attempts) begin
                     q_entry.r0.kind = KIND_DONE;
                     q_entry.r0.code = RC_TIMEOUT;
                  end else begin
                     q_entry.r0.kind  = KIND_REQ_CHUNK;
                     q_entry.r0.chunk = cur_ff;
                  end
               end
            end
            ACT_CHUNK: begin
               if (phase_ff == PH_CHUNK) begin
                  q_push = 1'b1;
                  if (chunk_bad) begin
                     q_entry.r0.kind = KIND_DONE;
                     q_entry.r0.code = RC_INVALID;
                  end else begin
                     q_entry.two       = 1'b1;
                     q_entry.r0.kind   = KIND_PAGE_WRITE;
                     q_entry.r0.chunk  = cur_ff;
                     q_entry.r0.offset = offset_ff;
                     if (!more) begin
                        q_entry.r1.kind = KIND_DONE;
                        q_entry.r1.code = RC_SUCCESS;
                     end else if (no_attempts) begin
                        q_entry.r1.kind = KIND_DONE;
                        q_entry.r1.code = RC_TIMEOUT;
                     end else begin
                        q_entry.r1.kind  = KIND_REQ_CHUNK;
                        q_entry.r1.chunk = cur_next;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         attempt_ff <= '0;
         wait_ff    <= '0;
         cur_ff     <= '0;
         offset_ff  <= '0;
         size_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         attempt_ff <= attempt_in;
         wait_ff    <= wait_in;
         cur_ff     <= cur_in;
         offset_ff  <= offset_in;
         size_ff    <= size_in;
      end
   end

endmodule

// ----- src/cidc_queue.sv -----
// cidc_queue: short queue of result entries between front and back
// depends on cidc_pkg

module cidc_queue import cidc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type wdata,
   input  logic      pop,
   output logic      full,
   output logic      empty,
   output entry_type rdata
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      full    = count_ff == CNT_W'(QUEUE_DEPTH);
      empty   = count_ff == '0;
      rdata   = slot_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop  = pop && !empty;
      wr_ptr_in = do_push ? PTR_W'((32'(wr_ptr_ff) + 1) % QUEUE_DEPTH) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PTR_W'((32'(rd_ptr_ff) + 1) % QUEUE_DEPTH) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/cidc_back.sv -----
// cidc_back: splits queue entries into single results, forms flash addresses,
// holds the result register; depends on cidc_pkg

module cidc_back import cidc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic [31:0] flash_base,
   input  logic      q_empty,
   input  entry_type q_head,
   output logic      q_pop,
   output logic      rsp_empty,
   input  logic      rsp_pop,
   output rsp_type   rsp_data
);

   logic     valid_ff, valid_in;
   logic     second_ff, second_in;
   rsp_type  out_ff, out_in;
   logic     load;
   item_type pick;

   always_comb begin
      load      = !valid_ff || rsp_pop;
      pick      = second_ff ? q_head.r1 : q_head.r0;
      valid_in  = valid_ff;
      second_in = second_ff;
      q_pop     = 1'b0;
      out_in    = out_ff;
      if (load) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            out_in.kind          = pick.kind;
            out_in.chunk_index   = pick.chunk;
            out_in.result_code   = pick.code;
            out_in.write_address = (pick.kind == KIND_PAGE_WRITE) ?
                                   flash_base + pick.offset : 32'd0;
            out_in.last          = second_ff || !q_head.two;
            // second half of a two-result entry comes next
            q_pop                = second_ff || !q_head.two;
            second_in            = !second_ff && q_head.two;
         end
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

endmodule

// ----- src/chunked_image_download_controller_core.sv -----
// chunked image download controller, requester side
// latency: a request's results pass through the result queue and then the output register
// throughput: one request per cycle while the four-entry result queue has room;
// results leave one per cycle from the output register while rsp_pop is held, one by one
// reset: synchronous, active high; state idle, registers to defaults, queue empty

module chunked_image_download_controller_core import cidc_pkg::*; #(
   parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   logic      req_accept;
   logic      q_push;
   entry_type q_entry;
   logic      q_pop;
   logic      q_empty;
   entry_type q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FLASH_BASE: cfg_in.flash_base     = csr_wdata;
            CSR_MAGIC:      cfg_in.expected_magic = csr_wdata;
            CSR_MAX_ATT:    cfg_in.max_attempts   = csr_wdata[3:0];
            CSR_TIMEOUT:    cfg_in.step_timeout   = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flash_base     <= '0;
         cfg_ff.expected_magic <= '0;
         cfg_ff.max_attempts   <= MAX_ATT_RST;
         cfg_ff.step_timeout   <= TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_accept = req_push && !req_full;

   cidc_front #(
      .PAGE_BYTES(PAGE_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_accept (req_accept),
      .req        (req_data),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   cidc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_entry),
      .pop   (q_pop),
      .full  (req_full),
      .empty (q_empty),
      .rdata (q_head)
   );

   cidc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .flash_base (cfg_ff.flash_base),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // a page write is always followed by a completion or the next chunk request
   a_write_not_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.kind == KIND_PAGE_WRITE) |-> !rsp_data.last)
      else $error("page write marked as last result");

   // completions and rejects always end their request
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.kind == KIND_DONE || rsp_data.kind == KIND_REJECT))
      |-> rsp_data.last)
      else $error("completion not marked as last result");

   // only page writes carry an address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.kind != KIND_PAGE_WRITE) |-> rsp_data.write_address == 32'd0)
      else $error("address on a result that is not a page write");

   // nothing is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("results pending after reset");
`endif

endmodule

// ----- sim/download_checker.sv -----
`timescale 1ns / 100ps
// download_checker: watches the request, result and csr ports of the download controller,
// predicts the results of every accepted request and compares them; depends on cidc_pkg

module download_checker import cidc_pkg::*; #(
   parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  req_type     req_data,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          outstanding
);

   localparam int PRINT_CAP = 40;

   cfg_type            cfg;
   phase_type          phase;
   logic [3:0]         attempts;
   logic [15:0]        waited;
   logic [CHUNK_W-1:0] cur_chunk;
   logic [CHUNK_W-1:0] chunk_total;

   rsp_type expected_rsp[$];
   rsp_type step_rsp[$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string what);
      if (fail_count < PRINT_CAP)
         $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   task automatic emit_rsp(input logic [2:0] kind, input logic [CHUNK_W-1:0] chunk,
                           input logic [31:0] addr, input logic [1:0] code);
      rsp_type r;
      r.kind          = kind;
      r.chunk_index   = chunk;
      r.write_address = addr;
      r.result_code   = code;
      r.last          = 1'b0;
      step_rsp.push_back(r);
   endtask

   task automatic conclude(input logic [1:0] code);
      phase    = PH_IDLE;
      attempts = '0;
      waited   = '0;
      emit_rsp(KIND_DONE, '0, '0, code);
   endtask

   // one more attempt at the current step, or give up
   task automatic issue_step();
      if (attempts >= cfg.max_attempts) begin
         conclude(RC_TIMEOUT);
      end else begin
         attempts = attempts + 4'd1;
         waited   = '0;
         if (phase == PH_META)
            emit_rsp(KIND_REQ_META, '0, '0, '0);
         else
            emit_rsp(KIND_REQ_CHUNK, cur_chunk, '0, '0);
      end
   endtask

   task automatic predict_request(input req_type r);
      logic [63:0] total;
      logic [15:0] limit;
      logic [31:0] offset;
      step_rsp.delete();
      case (r.action)
         ACT_START: begin
            if (phase != PH_IDLE) begin
               emit_rsp(KIND_REJECT, '0, '0, '0);
            end else begin
               phase     = PH_META;
               attempts  = '0;
               waited    = '0;
               cur_chunk = '0;
               issue_step();
            end
         end
         ACT_TICK: begin
            if (phase != PH_IDLE) begin
               limit = (cfg.step_timeout == '0) ? 16'd1 : cfg.step_timeout;
               if (waited != 16'hFFFF)
                  waited = waited + 16'd1;
               if (waited >= limit)
                  issue_step();
            end
         end
         ACT_META: begin
            if (phase == PH_META) begin
               total = 64'(r.image_size) / 64'(PAGE_BYTES) + 64'd1;
               if (r.image_magic != cfg.expected_magic) begin
                  conclude(RC_MAGIC);
               end else if (r.image_size == '0 || total > 64'(CHUNK_MAX)) begin
                  conclude(RC_INVALID);
               end else begin
                  chunk_total = total[CHUNK_W-1:0];
                  phase       = PH_CHUNK;
                  attempts    = '0;
                  waited      = '0;
                  issue_step();
               end
            end
         end
         ACT_CHUNK: begin
            if (phase == PH_CHUNK) begin
               if (r.chunk_number != cur_chunk) begin
                  conclude(RC_INVALID);
               end else begin
                  offset = 32'(r.chunk_number) * 32'(PAGE_BYTES);
                  emit_rsp(KIND_PAGE_WRITE, r.chunk_number, cfg.flash_base + offset, '0);
                  cur_chunk = cur_chunk + 1'b1;
                  if (cur_chunk < chunk_total) begin
                     attempts = '0;
                     waited   = '0;
                     issue_step();
                  end else begin
                     conclude(RC_SUCCESS);
                  end
               end
            end
         end
         ACT_PEER: begin
            phase    = PH_IDLE;
            attempts = '0;
            waited   = '0;
         end
         default: ;
      endcase
      if (step_rsp.size() > 0)
         step_rsp[step_rsp.size()-1].last = 1'b1;
      foreach (step_rsp[i])
         expected_rsp.push_back(step_rsp[i]);
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_rsp.size() == 0) begin
         report_mismatch($sformatf("result kind %0d with nothing expected", got.kind));
      end else begin
         want = expected_rsp.pop_front();
         if (got.kind != want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
         if (got.chunk_index != want.chunk_index)
            report_mismatch($sformatf("chunk_index %0d, expected %0d",
                                      got.chunk_index, want.chunk_index));
         if (got.write_address != want.write_address)
            report_mismatch($sformatf("write_address %h, expected %h",
                                      got.write_address, want.write_address));
         if (got.result_code != want.result_code)
            report_mismatch($sformatf("result_code %0d, expected %0d",
                                      got.result_code, want.result_code));
         if (got.last != want.last)
            report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.flash_base     = '0;
         cfg.expected_magic = '0;
         cfg.max_attempts   = MAX_ATT_RST;
         cfg.step_timeout   = TIMEOUT_RST;
         phase              = PH_IDLE;
         attempts           = '0;
         waited             = '0;
         cur_chunk          = '0;
         chunk_total        = '0;
         expected_rsp.delete();
      end else begin
         // a result seen here always belongs to an earlier request
         if (!rsp_empty && rsp_pop)
            check_result(rsp_data);
         if (req_push && !req_full)
            predict_request(req_data);
         if (csr_we) begin
            case (csr_index)
               CSR_FLASH_BASE: cfg.flash_base     = csr_wdata;
               CSR_MAGIC:      cfg.expected_magic = csr_wdata;
               CSR_MAX_ATT:    cfg.max_attempts   = csr_wdata[3:0];
               CSR_TIMEOUT:    cfg.step_timeout   = csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      outstanding = expected_rsp.size();
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// testbench: directed then random requests into the chunked image download controller,
// random stalls on both sides; depends on cidc_pkg, the core and download_checker

module testbench;
   import cidc_pkg::*;

   localparam int PAGE        = PAGE_BYTES_DEF;
   localparam int ITEM_GOAL   = 1450;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 10;
   localparam int HOLD_CYCLES = 400;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_push  = 1'b0;
   req_type     req_data  = '0;
   logic        rsp_pop   = 1'b0;
   logic        csr_we    = 1'b0;
   logic [1:0]  csr_index = CSR_FLASH_BASE;
   logic [31:0] csr_wdata = '0;
   logic        req_full;
   logic        rsp_empty;
   rsp_type     rsp_data;
   int          fail_count;
   int          outstanding;

   int          cycle_count = 0;
   int          counted     = 0;
   int          holds_asked = 0;
   bit          tx_steady   = 1'b0;
   bit          rx_steady   = 1'b0;
   logic [31:0] magic_now   = '0;

   chunked_image_download_controller_core #(.PAGE_BYTES(PAGE)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   download_checker #(.PAGE_BYTES(PAGE)) watch (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return 0;
      else if (roll < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int tick_count();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 6)
         return 0;
      else if (roll < 9)
         return $urandom_range(1, 3);
      return $urandom_range(4, 12);
   endfunction

   function automatic req_type noise_fields(input logic [2:0] act);
      req_type r;
      r.action       = act;
      r.image_magic  = $urandom;
      r.image_size   = $urandom;
      r.chunk_number = CHUNK_W'($urandom);
      return r;
   endfunction

   // result side: random stalls plus the long hold-offs asked for by the stimulus
   initial begin
      int stall;
      int holds_done;
      stall      = 0;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (holds_done != holds_asked) begin
            holds_done = holds_asked;
            stall      = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else begin
            rsp_pop <= 1'b1;
            if (!rx_steady)
               stall = pick_gap();
         end
      end
   end

   task automatic push_request(input req_type r);
      int gap;
      req_data <= r;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      @(negedge clock);
      counted++;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic do_action(input logic [2:0] act);
      push_request(noise_fields(act));
   endtask

   task automatic send_meta(input logic [31:0] magic, input logic [31:0] size);
      req_type r;
      r             = noise_fields(ACT_META);
      r.image_magic = magic;
      r.image_size  = size;
      push_request(r);
   endtask

   task automatic send_chunk(input logic [CHUNK_W-1:0] chunk);
      req_type r;
      r              = noise_fields(ACT_CHUNK);
      r.chunk_number = chunk;
      push_request(r);
   endtask

   task automatic send_ticks(input int n);
      repeat (n) do_action(ACT_TICK);
   endtask

   // wait for every expected result, then let requests with no result drain too
   task automatic quiesce();
      req_push <= 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic program_csr(input logic [31:0] base, input logic [31:0] magic,
                              input logic [3:0] att, input logic [15:0] tmo);
      quiesce();
      csr_we    <= 1'b1;
      csr_index <= CSR_FLASH_BASE;
      csr_wdata <= base;
      @(negedge clock);
      csr_index <= CSR_MAGIC;
      csr_wdata <= magic;
      @(negedge clock);
      csr_index <= CSR_MAX_ATT;
      csr_wdata <= {28'd0, att};
      @(negedge clock);
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= {16'd0, tmo};
      @(negedge clock);
      csr_we    <= 1'b0;
      magic_now = magic;
   endtask

   task automatic random_setup(input int n);
      logic [31:0] base;
      logic [31:0] magic;
      logic [3:0]  att;
      logic [15:0] tmo;
      case (n % 5)
         0: begin base = 32'hFFFF_FFFF; magic = 32'h0; end
         1: begin base = 32'h0; magic = 32'hFFFF_FFFF; end
         default: begin base = $urandom; magic = $urandom; end
      endcase
      case (n % 8)
         0, 7: att = 4'd15;
         1: att = 4'd2;
         2: att = 4'd3;
         3: att = 4'd0;
         4: att = 4'd1;
         5: att = 4'($urandom_range(1, 15));
         default: att = 4'd4;
      endcase
      case (n % 6)
         0: tmo = 16'd1;
         1: tmo = 16'd2;
         2: tmo = 16'd0;
         3: tmo = 16'hFFFF;
         4: tmo = 16'd3;
         default: tmo = 16'($urandom_range(1, 5));
      endcase
      program_csr(base, magic, att, tmo);
   endtask

   // one download attempt with random content, retries and the odd disturbance
   task automatic run_download();
      int roll;
      int total;
      bit big;
      logic [31:0] size;
      big = 1'b0;
      do_action(ACT_START);
      send_ticks(tick_count());
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         send_meta(magic_now ^ ($urandom | 32'd1), $urandom);
         return;
      end else if (roll < 12) begin
         send_meta(magic_now, '0);
         return;
      end else if (roll < 20) begin
         size = $urandom;
         send_meta(magic_now, size);
         total = 3;
         big   = 1'b1;
      end else begin
         size = $urandom_range(1, 5 * PAGE);
         send_meta(magic_now, size);
         total = size / PAGE + 1;
      end
      for (int c = 0; c < total; c++) begin
         send_ticks(tick_count());
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            send_chunk(CHUNK_W'($urandom));
            return;
         end else if (roll < 7) begin
            do_action(ACT_START);
         end else if (roll < 9) begin
            do_action(ACT_PEER);
            return;
         end else if (roll < 11) begin
            send_meta(magic_now, $urandom);
         end else if (roll < 13) begin
            do_action(3'($urandom_range(5, 7)));
         end
         send_chunk(CHUNK_W'(c));
      end
      if (big)
         do_action(ACT_PEER);
   endtask

   initial begin
      int phase_no;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults: matching zero magic, three chunks, then abandon
      do_action(ACT_START);
      send_meta(32'h0, 32'd4096);
      do_action(ACT_PEER);

      // zero timeout retries on every tick, two attempts, base near the top of memory
      program_csr(32'hFFFF_F000, 32'hFFFF_FFFF, 4'd2, 16'd0);
      do_action(ACT_TICK);
      send_meta(32'hFFFF_FFFF, 32'd100);
      do_action(ACT_START);
      do_action(ACT_START);
      do_action(ACT_TICK);
      do_action(ACT_TICK);
      do_action(ACT_START);
      send_chunk('0);
      send_meta(32'h0, 32'd100);
      do_action(ACT_START);
      send_meta(32'hFFFF_FFFF, 32'h0);
      do_action(ACT_START);
      send_meta(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_chunk(22'd0);
      send_chunk(22'd1);
      send_chunk(CHUNK_MAX);
      do_action(ACT_START);
      send_meta(32'hFFFF_FFFF, 32'd2048);
      send_meta(32'hFFFF_FFFF, 32'd2048);
      send_chunk(22'd0);
      send_chunk(22'd1);
      do_action(3'd5);

      // no attempts allowed: start ends at once
      program_csr(32'h1234_5678, 32'hA5A5_5A5A, 4'd0, 16'hFFFF);
      do_action(ACT_START);
      do_action(3'd7);

      phase_no = 0;
      while (counted < ITEM_GOAL) begin
         random_setup(phase_no);
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         for (int d = 0; d < 15 && counted < ITEM_GOAL; d++) begin
            if (d == 5 && phase_no % 3 == 1)
               holds_asked++;
            run_download();
         end
         phase_no++;
      end

      quiesce();
      if (fail_count == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
